/* sv/bitstream_field_vbr_reader_defines.svh */
// ---------------------------------------------------------------------------
// bitstream_field_vbr_reader_defines
// assertion macros used by the bitstream reader checker
// ---------------------------------------------------------------------------
`ifndef BITSTREAM_FIELD_VBR_READER_DEFINES_SVH
`define BITSTREAM_FIELD_VBR_READER_DEFINES_SVH

// same-cycle implication
`define BFVR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BFVR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/bfvr_pkg.sv */
// ---------------------------------------------------------------------------
// bfvr_pkg
// shared constants and types of the bitstream field / vbr reader
// ---------------------------------------------------------------------------
package bfvr_pkg;

   // default byte store depth
   localparam int BUFFER_BYTES_DEF = 4096;

   // field widths
   localparam int SIZE_W  = 13;
   localparam int OFFS_W  = 13;
   localparam int POS_W   = 16;
   localparam int VALUE_W = 64;

   // request function codes
   localparam logic [2:0] FUNC_LOAD  = 3'd0;
   localparam logic [2:0] FUNC_FIXED = 3'd1;
   localparam logic [2:0] FUNC_WIDE  = 3'd2;
   localparam logic [2:0] FUNC_VBR   = 3'd3;
   localparam logic [2:0] FUNC_ALIGN = 3'd4;
   localparam logic [2:0] FUNC_SEEK  = 3'd5;
   localparam logic [2:0] FUNC_TELL  = 3'd6;

   // finished result handed from the engine to the output register
   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic [POS_W-1:0]   bit_position;
      logic               at_end;
   } bfvr_rsp_type;

endpackage

/* sv/bitstream_field_vbr_reader.sv */
// ---------------------------------------------------------------------------
// bitstream_field_vbr_reader
// Sequence: an accepted load, align, tell or byte seek goes straight from
// idle to the done state; reads, and seeks to a bit, pass through the part
// and post states per part (a wide read has two, a vbr read one per chunk).
// Throughput: one item at a time, bounded by the one-byte-per-cycle store port.
// Reset clears the cursor, data_size and rsp_valid; the byte store is not cleared.
// ---------------------------------------------------------------------------
module bitstream_field_vbr_reader #(
   parameter int BUFFER_BYTES = bfvr_pkg::BUFFER_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [12:0] csr_data_size,
   // request items
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_func,
   input  logic [6:0]  req_width,
   input  logic [11:0] req_load_address,
   input  logic [7:0]  req_load_byte,
   input  logic [15:0] req_seek_position,
   // result items
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_value,
   output logic [15:0] rsp_bit_position,
   output logic        rsp_at_end
);

   localparam int          AW       = $clog2(BUFFER_BYTES);
   localparam int          SIZE_CAP = (BUFFER_BYTES > 8191) ? 8191 : BUFFER_BYTES;
   localparam logic [12:0] SizeCap  = 13'(SIZE_CAP);

   logic [12:0]            data_size_ff;
   logic [12:0]            eff_size;
   logic                   mem_we;
   logic [AW-1:0]          mem_waddr;
   logic [7:0]             mem_wdata;
   logic [AW-1:0]          mem_raddr;
   logic [7:0]             mem_rdata;
   logic                   done_valid;
   logic                   done_ready;
   bfvr_pkg::bfvr_rsp_type done_rsp;
   logic                   rsp_valid_ff;
   bfvr_pkg::bfvr_rsp_type rsp_ff;

   // data size register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         data_size_ff <= '0;
      end else if (csr_valid) begin
         data_size_ff <= csr_data_size;
      end
   end

   // sizes above the store depth, or above 8191, act as the smaller of the two
   assign eff_size = (data_size_ff > SizeCap) ? SizeCap : data_size_ff;

   bfvr_byte_mem #(
      .DEPTH   (BUFFER_BYTES)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   bfvr_engine #(
      .BUFFER_BYTES      (BUFFER_BYTES)
   ) u_engine (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_func          (req_func),
      .req_width         (req_width),
      .req_load_address  (req_load_address),
      .req_load_byte     (req_load_byte),
      .req_seek_position (req_seek_position),
      .eff_size          (eff_size),
      .mem_we            (mem_we),
      .mem_waddr         (mem_waddr),
      .mem_wdata         (mem_wdata),
      .mem_raddr         (mem_raddr),
      .mem_rdata         (mem_rdata),
      .done_valid        (done_valid),
      .done_ready        (done_ready),
      .done_rsp          (done_rsp)
   );

   // output register
   assign done_ready = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (done_valid && done_ready) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (done_valid && done_ready) begin
         rsp_ff <= done_rsp;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_value        = rsp_ff.value;
   assign rsp_bit_position = rsp_ff.bit_position;
   assign rsp_at_end       = rsp_ff.at_end;

endmodule

/* sv/bfvr_byte_mem.sv */
// ---------------------------------------------------------------------------
// bfvr_byte_mem
// byte store: one write port, one read port, registered read data
// ---------------------------------------------------------------------------
module bfvr_byte_mem #(
   parameter int  DEPTH = bfvr_pkg::BUFFER_BYTES_DEF,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] store_ff [DEPTH];
   logic [7:0] rd_data_ff;

   // write, and read with registered read data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/bfvr_engine.sv */
// ---------------------------------------------------------------------------
// bfvr_engine
// cursor state and request sequencer; pulls bits from the byte store
// ---------------------------------------------------------------------------
module bfvr_engine #(
   parameter int  BUFFER_BYTES = bfvr_pkg::BUFFER_BYTES_DEF,
   localparam int AW           = $clog2(BUFFER_BYTES)
) (
   input  logic                       clock,
   input  logic                       reset,
   // request side
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [2:0]                 req_func,
   input  logic [6:0]                 req_width,
   input  logic [11:0]                req_load_address,
   input  logic [7:0]                 req_load_byte,
   input  logic [15:0]                req_seek_position,
   // effective data size
   input  logic [12:0]                eff_size,
   // byte store
   output logic                       mem_we,
   output logic [AW-1:0]              mem_waddr,
   output logic [7:0]                 mem_wdata,
   output logic [AW-1:0]              mem_raddr,
   input  logic [7:0]                 mem_rdata,
   // finished result
   output logic                       done_valid,
   input  logic                       done_ready,
   output bfvr_pkg::bfvr_rsp_type     done_rsp
);

   // sequencer states
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_PART = 2'd1;
   localparam logic [1:0] S_POST = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   // what the collected part is used for
   localparam logic [1:0] MODE_FIXED = 2'd0;
   localparam logic [1:0] MODE_VBR   = 2'd1;
   localparam logic [1:0] MODE_SEEK  = 2'd2;

   // control state
   logic [1:0]  state_ff, state_in;
   logic [1:0]  mode_ff, mode_in;
   logic        wide_lo_ff, wide_lo_in;
   logic        wide_hi_ff, wide_hi_in;
   logic        fresh_ff, fresh_in;
   logic [12:0] byte_offset_ff, byte_offset_in;
   logic [7:0]  cur_byte_ff, cur_byte_in;
   logic [3:0]  bits_rem_ff, bits_rem_in;
   logic [5:0]  n_ff, n_in;
   logic [5:0]  got_ff, got_in;

   // payload state
   logic [31:0] pacc_ff, pacc_in;
   logic [63:0] result_ff, result_in;
   logic [6:0]  vpos_ff, vpos_in;
   logic [5:0]  vw_ff, vw_in;
   logic [5:0]  rest_ff, rest_in;

   // bit extraction
   logic        at_end_now;
   logic        fetch;
   logic [7:0]  src;
   logic [3:0]  avail;
   logic [5:0]  need;
   logic [3:0]  k;
   logic [7:0]  take_bits;
   logic [31:0] pacc_add;
   logic [5:0]  got_next;

   // request decode helpers
   logic [6:0]  wide_n;
   logic [5:0]  vbr_w;
   logic [13:0] align_up;
   logic [12:0] align_target;
   logic        load_in_range;
   logic [31:0] load_addr_wide;
   logic [31:0] raddr_wide;

   // vbr merge
   logic [4:0]  vw_m1;
   logic [31:0] payload;
   logic [63:0] payload_shift;

   assign at_end_now = (byte_offset_ff >= eff_size);

   // one step of bits from the buffered byte or a freshly read one
   always_comb begin
      fetch     = (bits_rem_ff == 4'd0);
      src       = fetch ? mem_rdata : cur_byte_ff;
      avail     = fetch ? 4'd8 : bits_rem_ff;
      need      = n_ff - got_ff;
      k         = (need > {2'b00, avail}) ? avail : need[3:0];
      take_bits = src & ~(8'hFF << k);
      pacc_add  = {24'd0, take_bits} << got_ff[4:0];
      got_next  = got_ff + {2'b00, k};
   end

   // decode helpers for a new request
   always_comb begin
      wide_n         = (req_width > 7'd64) ? 7'd64 : req_width;
      if (req_width < 7'd2) begin
         vbr_w = 6'd2;
      end else if (req_width > 7'd32) begin
         vbr_w = 6'd32;
      end else begin
         vbr_w = req_width[5:0];
      end
      align_up       = {1'b0, byte_offset_ff[12:2], 2'b00} + 14'd4;
      align_target   = (align_up > {1'b0, eff_size}) ? eff_size : align_up[12:0];
      load_addr_wide = {20'd0, req_load_address};
      load_in_range  = (load_addr_wide < 32'(BUFFER_BYTES));
   end

   // vbr chunk payload placed at the running offset
   always_comb begin
      vw_m1         = 5'(vw_ff - 6'd1);
      payload       = pacc_ff & ~(32'hFFFF_FFFF << vw_m1);
      payload_shift = {32'd0, payload} << vpos_ff[5:0];
   end

   // sequencer
   always_comb begin
      state_in       = state_ff;
      mode_in        = mode_ff;
      wide_lo_in     = wide_lo_ff;
      wide_hi_in     = wide_hi_ff;
      byte_offset_in = byte_offset_ff;
      cur_byte_in    = cur_byte_ff;
      bits_rem_in    = bits_rem_ff;
      n_in           = n_ff;
      got_in         = got_ff;
      pacc_in        = pacc_ff;
      result_in      = result_ff;
      vpos_in        = vpos_ff;
      vw_in          = vw_ff;
      rest_in        = rest_ff;
      mem_we         = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               result_in  = '0;
               pacc_in    = '0;
               got_in     = '0;
               wide_lo_in = 1'b0;
               wide_hi_in = 1'b0;
               mode_in    = MODE_FIXED;
               state_in   = S_DONE;
               unique case (req_func)
                  bfvr_pkg::FUNC_LOAD: begin
                     mem_we = load_in_range;
                  end
                  bfvr_pkg::FUNC_FIXED: begin
                     n_in     = (req_width > 7'd32) ? 6'd32 : req_width[5:0];
                     state_in = S_PART;
                  end
                  bfvr_pkg::FUNC_WIDE: begin
                     if (wide_n > 7'd32) begin
                        n_in       = 6'd32;
                        rest_in    = 6'(wide_n - 7'd32);
                        wide_lo_in = 1'b1;
                     end else begin
                        n_in = wide_n[5:0];
                     end
                     state_in = S_PART;
                  end
                  bfvr_pkg::FUNC_VBR: begin
                     mode_in  = MODE_VBR;
                     n_in     = vbr_w;
                     vw_in    = vbr_w;
                     vpos_in  = '0;
                     state_in = S_PART;
                  end
                  bfvr_pkg::FUNC_ALIGN: begin
                     if (!at_end_now && (byte_offset_ff[1:0] != 2'b00)) begin
                        byte_offset_in = align_target;
                     end
                     bits_rem_in = '0;
                  end
                  bfvr_pkg::FUNC_SEEK: begin
                     byte_offset_in = req_seek_position[15:3];
                     bits_rem_in    = '0;
                     if (req_seek_position[2:0] != 3'b000) begin
                        mode_in  = MODE_SEEK;
                        n_in     = {3'b000, req_seek_position[2:0]};
                        state_in = S_PART;
                     end
                  end
                  default: begin
                     // tell and the unused code change nothing
                  end
               endcase
            end
         end

         S_PART: begin
            priority if (got_ff == n_ff) begin
               state_in = S_POST;
            end else if (fetch && at_end_now) begin
               // ran out of data: this part reads as zero
               pacc_in  = '0;
               state_in = S_POST;
            end else if (fetch && !fresh_ff) begin
               // read data not yet valid for the cursor, wait
            end else begin
               pacc_in     = pacc_ff | pacc_add;
               cur_byte_in = src >> k;
               bits_rem_in = avail - k;
               got_in      = got_next;
               if (fetch) begin
                  byte_offset_in = byte_offset_ff + 13'd1;
               end
               if (got_next == n_ff) begin
                  state_in = S_POST;
               end
            end
         end

         S_POST: begin
            state_in = S_DONE;
            unique case (mode_ff)
               MODE_FIXED: begin
                  if (wide_lo_ff) begin
                     // low word done, go on with the high part
                     result_in[31:0] = pacc_ff;
                     wide_lo_in      = 1'b0;
                     wide_hi_in      = 1'b1;
                     n_in            = rest_ff;
                     got_in          = '0;
                     pacc_in         = '0;
                     state_in        = S_PART;
                  end else if (wide_hi_ff) begin
                     result_in[63:32] = pacc_ff;
                  end else begin
                     result_in = {32'd0, pacc_ff};
                  end
               end
               MODE_VBR: begin
                  if (vpos_ff < 7'd64) begin
                     result_in = result_ff | payload_shift;
                     vpos_in   = vpos_ff + {2'b00, vw_m1};
                  end
                  if (pacc_ff[vw_m1]) begin
                     got_in   = '0;
                     pacc_in  = '0;
                     state_in = S_PART;
                  end
               end
               default: begin
                  // seek skip bits are dropped
               end
            endcase
         end

         S_DONE: begin
            if (done_ready) begin
               state_in = S_IDLE;
            end
         end
      endcase
   end

   // store read data matches the cursor unless a write got in between
   assign fresh_in = !mem_we;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         mode_ff        <= MODE_FIXED;
         wide_lo_ff     <= 1'b0;
         wide_hi_ff     <= 1'b0;
         fresh_ff       <= 1'b0;
         byte_offset_ff <= '0;
         cur_byte_ff    <= '0;
         bits_rem_ff    <= '0;
         n_ff           <= '0;
         got_ff         <= '0;
      end else begin
         state_ff       <= state_in;
         mode_ff        <= mode_in;
         wide_lo_ff     <= wide_lo_in;
         wide_hi_ff     <= wide_hi_in;
         fresh_ff       <= fresh_in;
         byte_offset_ff <= byte_offset_in;
         cur_byte_ff    <= cur_byte_in;
         bits_rem_ff    <= bits_rem_in;
         n_ff           <= n_in;
         got_ff         <= got_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pacc_ff   <= pacc_in;
      result_ff <= result_in;
      vpos_ff   <= vpos_in;
      vw_ff     <= vw_in;
      rest_ff   <= rest_in;
   end

   // store ports: read always follows the next cursor
   assign raddr_wide = 32'(byte_offset_in);
   assign mem_raddr  = raddr_wide[AW-1:0];
   assign mem_waddr  = load_addr_wide[AW-1:0];
   assign mem_wdata  = req_load_byte;

   // handshake and result
   assign req_ready              = (state_ff == S_IDLE);
   assign done_valid             = (state_ff == S_DONE);
   assign done_rsp.value         = result_ff;
   assign done_rsp.bit_position  = {byte_offset_ff, 3'b000} - {12'd0, bits_rem_ff};
   assign done_rsp.at_end        = at_end_now && (bits_rem_ff == 4'd0);

endmodule

/* sv/bfvr_checker.sv */
// ---------------------------------------------------------------------------
// bfvr_checker
// port-level checks of the bitstream reader, bound to the top level
// ---------------------------------------------------------------------------
`include "bitstream_field_vbr_reader_defines.svh"

module bfvr_checker (
   input logic        clock,
   input logic        reset,
   input logic        csr_valid,
   input logic        csr_ready,
   input logic [12:0] csr_data_size,
   input logic        req_valid,
   input logic        req_ready,
   input logic [2:0]  req_func,
   input logic [6:0]  req_width,
   input logic [11:0] req_load_address,
   input logic [7:0]  req_load_byte,
   input logic [15:0] req_seek_position,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [63:0] rsp_value,
   input logic [15:0] rsp_bit_position,
   input logic        rsp_at_end
);

   // a stalled result holds
   `BFVR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_value) && $stable(rsp_bit_position), "result changed while stalled")

   // one item in flight: ready drops after an accept
   `BFVR_ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && req_ready, !req_ready, "second item taken while one is in flight")

   // at end means no bits buffered, so the position sits on a byte
   `BFVR_ASSERT_NOW(a_end_on_byte, clock, reset, rsp_valid && rsp_at_end, rsp_bit_position[2:0] == 3'b000, "at_end with a partial byte")

   // a result never shows the cycle right after its item is taken
   `BFVR_ASSERT_NOW(a_min_latency, clock, reset, $rose(rsp_valid), !$past(req_valid && req_ready), "result appeared too early")

endmodule

bind bitstream_field_vbr_reader bfvr_checker u_checker (.*);
